// ----- src/sdcq_pkg.sv -----
package sdcq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;

  localparam logic [7:0] ANY_MASK_RST = 8'h1f;
  localparam logic [7:0] ERR_MASK_RST = 8'h1e;
  localparam logic [3:0] RETRY_RST    = 4'd3;
  localparam logic [3:0] COUNT_MASK   = 4'hf;

  localparam logic [1:0] REG_ANY_MASK = 2'd0;
  localparam logic [1:0] REG_ERR_MASK = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_POLL    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_INIT    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_SUCCESS = 3'd3,
    ST_FAILED  = 3'd4
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] command_word;
    logic [31:0] command_argument;
    logic [31:0] expect_mask;
    logic [31:0] expect_value;
    logic        repeat_until_match;
    logic [31:0] user_tag;
    logic [7:0]  event_status;
    logic [31:0] response_word;
  } in_item_t;

  typedef struct packed {
    logic        issue_valid;
    logic [31:0] issue_command;
    logic [31:0] issue_argument;
    eng_state_t  engine_state;
    logic        notify_valid;
    logic [31:0] notify_tag;
    logic [31:0] latest_response;
    logic        accepted;
    logic [3:0]  queue_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0] any_mask;
    logic [7:0] err_mask;
    logic [3:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] cmd;
    logic [31:0] arg;
  } cmd_entry_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] expect_val;
    logic        rpt;
    logic [31:0] tag;
  } chk_entry_t;

endpackage

// ----- src/sdcq_ram.sv -----
module sdcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sdcq_cfg.sv -----
module sdcq_cfg
  import sdcq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.any_mask    <= ANY_MASK_RST;
      cfg_r.err_mask    <= ERR_MASK_RST;
      cfg_r.retry_limit <= RETRY_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ANY_MASK: cfg_r.any_mask    <= pwdata[7:0];
        REG_ERR_MASK: cfg_r.err_mask    <= pwdata[7:0];
        REG_RETRY:    cfg_r.retry_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ANY_MASK: prdata = {24'b0, cfg_r.any_mask};
      REG_ERR_MASK: prdata = {24'b0, cfg_r.err_mask};
      REG_RETRY:    prdata = {28'b0, cfg_r.retry_limit};
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- src/sdcq_engine.sv -----
module sdcq_engine
  import sdcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  req,
  input  cfg_t      cfg,
  output out_item_t rsp
);

  localparam int PW = $clog2(2 * QUEUE_DEPTH);
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(2 * QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
    return s[SW-1:0];
  endfunction

  function automatic logic [CW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + (PW+1)'(2 * QUEUE_DEPTH);
    end
    return d[CW-1:0];
  endfunction

  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, rp_addr;
  eng_state_t    st_r, st_nxt;
  logic [3:0]    retry_r, retry_nxt;
  logic [31:0]   resp_r, resp_nxt;

  logic          byp_a_r, byp_b_r;
  cmd_entry_t    wr_cmd, wr_cmd_r, ram_a, ram_b, ent_a, ent_b;
  chk_entry_t    wr_chk, wr_chk_r, ram_c, ent_c;
  logic [SW-1:0] waddr, raddr_a, raddr_b;
  logic          we, we_go;

  logic [CW-1:0] fill, fill_after, fill_end;
  logic [31:0]   fill_ext;
  logic [7:0]    ev;
  logic          issue, sel_next, notify, acc, fail;

  assign wr_cmd  = '{cmd: req.command_word, arg: req.command_argument};
  assign wr_chk  = '{mask: req.expect_mask, expect_val: req.expect_value,
                     rpt: req.repeat_until_match, tag: req.user_tag};
  assign waddr   = slot_of(wp_r);
  assign we_go   = go && we;
  assign rp_addr = go ? rp_nxt : rp_r;
  assign raddr_a = slot_of(rp_addr);
  assign raddr_b = slot_of(ptr_inc(rp_addr));

  sdcq_ram #(.WIDTH($bits(cmd_entry_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_a (
    .clk, .we(we_go), .waddr, .wdata(wr_cmd), .raddr(raddr_a), .rdata(ram_a)
  );

  sdcq_ram #(.WIDTH($bits(cmd_entry_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_b (
    .clk, .we(we_go), .waddr, .wdata(wr_cmd), .raddr(raddr_b), .rdata(ram_b)
  );

  sdcq_ram #(.WIDTH($bits(chk_entry_t)), .DEPTH(QUEUE_DEPTH)) u_chk (
    .clk, .we(we_go), .waddr, .wdata(wr_chk), .raddr(raddr_a), .rdata(ram_c)
  );

  // forward an entry written at the last edge to the read side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      byp_a_r <= we_go && (waddr == raddr_a);
      byp_b_r <= we_go && (waddr == raddr_b);
    end
    wr_cmd_r <= wr_cmd;
    wr_chk_r <= wr_chk;
  end

  assign ent_a = byp_a_r ? wr_cmd_r : ram_a;
  assign ent_b = byp_b_r ? wr_cmd_r : ram_b;
  assign ent_c = byp_a_r ? wr_chk_r : ram_c;

  assign fill       = fill_of(wp_r, rp_r);
  assign fill_after = fill_of(wp_r, ptr_inc(rp_r));
  assign ev         = req.event_status & cfg.any_mask;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    st_nxt    = st_r;
    retry_nxt = retry_r;
    resp_nxt  = resp_r;
    we        = 1'b0;
    issue     = 1'b0;
    sel_next  = 1'b0;
    notify    = 1'b0;
    acc       = 1'b0;
    fail      = 1'b0;
    case (op_t'(req.operation))
      OP_ENQUEUE: begin
        if (fill < CW'(QUEUE_DEPTH)) begin
          we     = 1'b1;
          wp_nxt = ptr_inc(wp_r);
          acc    = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (st_r != ST_INIT) begin
          wp_nxt = '0;
          rp_nxt = '0;
          st_nxt = ST_IDLE;
        end
      end
      OP_RESTART: begin
        wp_nxt    = '0;
        rp_nxt    = '0;
        retry_nxt = '0;
        st_nxt    = ST_INIT;
      end
      OP_POLL: begin
        case (st_r)
          ST_IDLE, ST_INIT: begin
            if (fill != '0) begin
              st_nxt = ST_BUSY;
              issue  = 1'b1;
            end
          end
          ST_BUSY: begin
            if (ev != '0) begin
              resp_nxt = req.response_word;
              if ((ev & cfg.err_mask) != '0) begin
                if (retry_r < cfg.retry_limit) begin
                  retry_nxt = retry_r + 4'd1;
                  issue     = 1'b1;
                end else begin
                  fail = 1'b1;
                end
              end else begin
                retry_nxt = '0;
                if ((req.response_word & ent_c.mask) != ent_c.expect_val) begin
                  if (ent_c.rpt) begin
                    issue = 1'b1;
                  end else begin
                    fail = 1'b1;
                  end
                end else begin
                  rp_nxt = ptr_inc(rp_r);
                  if (fill_after != '0) begin
                    issue    = 1'b1;
                    sel_next = 1'b1;
                  end else begin
                    st_nxt = ST_SUCCESS;
                    notify = 1'b1;
                  end
                end
              end
              if (fail) begin
                notify    = 1'b1;
                wp_nxt    = '0;
                rp_nxt    = '0;
                retry_nxt = '0;
                st_nxt    = ST_FAILED;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      st_r    <= ST_INIT;
      retry_r <= '0;
      resp_r  <= '0;
    end else if (go) begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      st_r    <= st_nxt;
      retry_r <= retry_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign fill_end = fill_of(wp_nxt, rp_nxt);
  assign fill_ext = 32'(fill_end);

  always_comb begin
    rsp.issue_valid     = issue;
    rsp.issue_command   = issue ? (sel_next ? ent_b.cmd : ent_a.cmd) : '0;
    rsp.issue_argument  = issue ? (sel_next ? ent_b.arg : ent_a.arg) : '0;
    rsp.engine_state    = st_nxt;
    rsp.notify_valid    = notify;
    rsp.notify_tag      = notify ? ent_c.tag : '0;
    rsp.latest_response = resp_nxt;
    rsp.accepted        = acc;
    rsp.queue_count     = fill_ext[3:0] & COUNT_MASK;
  end

endmodule

// ----- src/sd_command_queue_sequencer.sv -----
// SD command queue sequencer.
// Input channel (in_valid/in_ready/in_data) carries one request per item:
// enqueue, poll, clear queue or restart. Every request yields exactly one
// result on the output channel (out_valid/out_ready/out_data) with the
// command to issue, the engine state, completion notice and queue count.
// Configuration (event masks, retry limit) is written over the APB port
// at byte addresses 0, 4 and 8; pready is always high.
// A request is registered on acceptance, decided combinationally once
// the output register is free, and its result is registered. Throughput
// is one request per cycle while out_ready does not stall, set by the
// single decision stage and the queue RAMs, which are read ahead at the
// next head pointer and forwarded on a same-slot write.
// Reset (synchronous, rst_n low) empties the queue, clears retries and
// the captured response, loads the register defaults and puts the engine
// in the initialising state. While out_ready is low the result holds,
// the input register keeps one request and in_ready is low while it is full.
module sd_command_queue_sequencer
  import sdcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic      in_valid_r, out_valid_r, out_valid_nxt, go;
  in_item_t  in_data_r;
  out_item_t out_data_r, rsp;
  cfg_t      cfg;

  assign go       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || go;

  sdcq_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  sdcq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
    .clk, .rst_n, .go, .req(in_data_r), .cfg, .rsp
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (go) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/sdcq_checker.sv -----
module sdcq_checker
  import sdcq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.issue_valid |-> out_data.engine_state == ST_BUSY)
    else $error("command issued outside busy state");

  a_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.issue_valid |->
      out_data.issue_command == '0 && out_data.issue_argument == '0)
    else $error("command fields set without issue");

  a_notify_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.notify_valid |->
      out_data.engine_state == ST_SUCCESS || out_data.engine_state == ST_FAILED)
    else $error("notify outside an end state");

  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.notify_valid && out_data.engine_state == ST_FAILED |->
      out_data.queue_count == '0 && !out_data.issue_valid)
    else $error("queue not emptied on failure");

endmodule

bind sd_command_queue_sequencer sdcq_checker u_sdcq_checker (.*);
